[sv/ccm_remote_endpoint_monitor_macros.svh]
// assertion helpers for the remote endpoint monitor
`ifndef CCM_REMOTE_ENDPOINT_MONITOR_MACROS_SVH
`define CCM_REMOTE_ENDPOINT_MONITOR_MACROS_SVH

// implication checked on every clock edge outside reset
`define CCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define CCM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ccm_pkg.sv]
`default_nettype none
package ccm_pkg;

  localparam int unsigned MAID_WORDS = 6;
  localparam logic [7:0] OPC_CCM = 8'd1;
  localparam int unsigned RDI_BIT = 7;

  localparam logic [63:0] LOCAL_MAID_0 = 64'h0403_6F76_7302_036F;
  localparam logic [63:0] LOCAL_MAID_1 = 64'h7673_0000_0000_0000;

  // configuration register indexes
  localparam logic CFG_LOCAL_MPID = 1'b0;
  localparam logic CFG_EXT_MODE   = 1'b1;

  typedef enum logic [2:0] {
    ST_BAD_OPCODE = 3'd0,
    ST_MAID_MISMATCH = 3'd1,
    ST_UPDATED = 3'd2,
    ST_INSERTED = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_CHECK_DONE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_LOOKUP_WAIT,
    S_TICK,
    S_TICK_WAIT,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture item
    logic scan_clear;  // zero scan index and search flags
    logic scan_step;   // evaluate entry at index, advance
    logic ccm_commit;  // write the found or free entry
    logic tick_start;  // open fault check
    logic tick_finish; // close fault check
    logic out_load;    // fill result register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic pre_done;   // wrong opcode or maid mismatch, no scan needed
    logic scan_last;  // index at final entry
    logic found;      // match hit during scan
  } sts_t;

endpackage
`default_nettype wire

[sv/ccm_ram.sv]
`default_nettype none
module ccm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/ccm_ctrl.sv]
`default_nettype none
module ccm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire ccm_pkg::sts_t  sts,
  output ccm_pkg::ctl_t       ctl
);

  ccm_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // sequencing: each entry is read in a wait state (S_LOOKUP_WAIT or S_TICK_WAIT), then evaluated in S_LOOKUP or S_TICK
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    in_ready = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ccm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          ctl.scan_clear = 1'b1;
          state_nxt = ccm_pkg::S_DONE;
        end
      end
      ccm_pkg::S_DONE: begin
        // dispatch on captured item
        if (sts.is_tick) begin
          ctl.tick_start = 1'b1;
          state_nxt = ccm_pkg::S_TICK_WAIT;
        end else if (sts.pre_done) begin
          if (!out_valid_r || out_ready) begin
            ctl.out_load = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt = ccm_pkg::S_IDLE;
          end
        end else begin
          state_nxt = ccm_pkg::S_LOOKUP_WAIT;
        end
      end
      ccm_pkg::S_LOOKUP_WAIT: begin
        state_nxt = ccm_pkg::S_LOOKUP;
      end
      ccm_pkg::S_LOOKUP: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last || sts.found) begin
          state_nxt = ccm_pkg::S_TICK;
        end else begin
          state_nxt = ccm_pkg::S_LOOKUP_WAIT;
        end
      end
      ccm_pkg::S_TICK_WAIT: begin
        state_nxt = ccm_pkg::S_TICK;
      end
      ccm_pkg::S_TICK: begin
        // tick scan step, or final commit of both kinds
        if (sts.is_tick && !sts.scan_last) begin
          ctl.scan_step = 1'b1;
          state_nxt = ccm_pkg::S_TICK_WAIT;
        end else if (!out_valid_r || out_ready) begin
          if (sts.is_tick) begin
            ctl.scan_step = 1'b1;
            ctl.tick_finish = 1'b1;
          end else begin
            ctl.ccm_commit = 1'b1;
          end
          ctl.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ccm_pkg::S_IDLE;
        end
      end
      default: state_nxt = ccm_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[sv/ccm_datapath.sv]
`default_nettype none
module ccm_datapath #(
  parameter int unsigned MAX_REMOTES = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ccm_pkg::ctl_t ctl,
  output ccm_pkg::sts_t      sts,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [63:0]   cfg_wdata,
  input  wire logic          in_operation,
  input  wire logic [7:0]    in_opcode,
  input  wire logic [7:0]    in_flags,
  input  wire logic [15:0]   in_short_mpid,
  input  wire logic [63:0]   in_long_mpid,
  input  wire logic [7:0]    in_opdown_byte,
  input  wire logic [63:0]   in_maid_word_0,
  input  wire logic [63:0]   in_maid_word_1,
  input  wire logic [63:0]   in_maid_word_2,
  input  wire logic [63:0]   in_maid_word_3,
  input  wire logic [63:0]   in_maid_word_4,
  input  wire logic [63:0]   in_maid_word_5,
  output logic [2:0]         out_status,
  output logic               out_fault,
  output logic               out_remote_up,
  output logic [8:0]         out_remote_count,
  output logic               out_unexpected_seen
);

  localparam int unsigned AW = (MAX_REMOTES > 1) ? $clog2(MAX_REMOTES) : 1;
  localparam int unsigned CW = $clog2(MAX_REMOTES + 1);
  localparam logic [AW-1:0] LAST = AW'(MAX_REMOTES - 1);
  // entry word: received, defect, up, mpid
  localparam int unsigned RW = 67;

  // configuration
  logic [63:0] local_mpid_r;
  logic        ext_mode_r;

  // captured item
  logic        is_tick_r;
  logic        pre_done_r;
  logic [2:0]  pre_status_r;
  logic [63:0] mpid_r;
  logic        rdi_r;
  logic        down_r;

  // per-entry valid bits
  logic [MAX_REMOTES-1:0] valid_r;

  // scan state
  logic [AW-1:0] idx_r;
  logic          found_r;
  logic [AW-1:0] hit_r;
  logic          free_ok_r;
  logic [AW-1:0] free_r;

  // flags
  logic          fault_r, unexp_r, rup_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] live_r;
  logic          tfault_r, trup_r;

  logic [RW-1:0] rd_word;
  logic [63:0]   rd_mpid;
  logic          rd_up;
  logic          rd_defect;
  logic          rd_rcv;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;

  ccm_ram #(.WIDTH(RW), .DEPTH(MAX_REMOTES)) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(rd_word)
  );

  assign rd_mpid = rd_word[63:0];
  assign rd_up = rd_word[64];
  assign rd_defect = rd_word[65];
  assign rd_rcv = rd_word[66];

  logic maid_ok;
  assign maid_ok = (in_maid_word_0 == ccm_pkg::LOCAL_MAID_0) &&
                   (in_maid_word_1 == ccm_pkg::LOCAL_MAID_1) &&
                   (in_maid_word_2 == '0) && (in_maid_word_3 == '0) &&
                   (in_maid_word_4 == '0) && (in_maid_word_5 == '0);

  logic cur_valid;
  logic hit_now;
  assign cur_valid = valid_r[idx_r];
  assign hit_now = cur_valid && (rd_mpid == mpid_r);

  assign sts.is_tick = is_tick_r;
  assign sts.pre_done = pre_done_r;
  assign sts.scan_last = (idx_r == LAST);
  assign sts.found = hit_now;

  // commit targets
  logic          do_insert;
  logic [AW-1:0] slot;
  logic          commit_wr;
  logic          tick_clr;
  logic          last_live;
  assign do_insert = !found_r && free_ok_r;
  assign slot = found_r ? hit_r : free_r;
  assign commit_wr = ctl.ccm_commit && (found_r || free_ok_r);
  assign tick_clr = ctl.scan_step && is_tick_r && cur_valid && rd_rcv;
  assign last_live = cur_valid && rd_rcv;

  // entry memory write: ccm commit or receive-mark clear during a check
  assign ram_we = commit_wr || tick_clr;
  assign ram_waddr = commit_wr ? slot : idx_r;
  assign ram_wdata = commit_wr ? {1'b1, rdi_r, !down_r, mpid_r} :
                                 {1'b0, rd_defect, rd_up, rd_mpid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mpid_r <= '0;
      ext_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == ccm_pkg::CFG_LOCAL_MPID) begin
        local_mpid_r <= cfg_wdata;
      end else begin
        ext_mode_r <= cfg_wdata[0];
      end
    end
  end

  // item capture and opcode / maid pre-check
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      is_tick_r <= in_operation;
      mpid_r <= ext_mode_r ? in_long_mpid : {48'd0, in_short_mpid};
      down_r <= ext_mode_r && (in_opdown_byte != 8'd0);
      rdi_r <= in_flags[ccm_pkg::RDI_BIT];
      pre_done_r <= (in_opcode != ccm_pkg::OPC_CCM) || !maid_ok;
      pre_status_r <= (in_opcode != ccm_pkg::OPC_CCM) ?
                      3'(ccm_pkg::ST_BAD_OPCODE) : 3'(ccm_pkg::ST_MAID_MISMATCH);
    end
  end

  // scan, table and flag updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fault_r <= 1'b0;
      unexp_r <= 1'b0;
      rup_r <= 1'b1;
      count_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else begin
      if (ctl.scan_clear) begin
        idx_r <= '0;
        found_r <= 1'b0;
        free_ok_r <= 1'b0;
      end
      // maid mismatch raises the flag together with its result
      if (ctl.out_load && !is_tick_r && pre_done_r &&
          pre_status_r == 3'(ccm_pkg::ST_MAID_MISMATCH)) begin
        unexp_r <= 1'b1;
      end
      if (ctl.tick_start) begin
        live_r <= '0;
        tfault_r <= unexp_r;
        trup_r <= 1'b1;
      end
      if (ctl.scan_step) begin
        if (idx_r != LAST) begin
          idx_r <= idx_r + AW'(1);
        end
        if (is_tick_r) begin
          if (cur_valid) begin
            if (!rd_rcv) begin
              valid_r[idx_r] <= 1'b0;
            end else begin
              live_r <= live_r + CW'(1);
              if (rd_mpid == local_mpid_r || rd_defect) begin
                tfault_r <= 1'b1;
              end
              if (!rd_up) begin
                trup_r <= 1'b0;
              end
            end
          end
        end else begin
          if (hit_now) begin
            found_r <= 1'b1;
            hit_r <= idx_r;
          end
          if (!cur_valid && !free_ok_r) begin
            free_ok_r <= 1'b1;
            free_r <= idx_r;
          end
        end
      end
      if (ctl.ccm_commit) begin
        if (found_r || free_ok_r) begin
          if (do_insert) begin
            valid_r[slot] <= 1'b1;
            count_r <= count_r + CW'(1);
          end
        end else begin
          unexp_r <= 1'b1;
        end
      end
      if (ctl.tick_finish) begin
        // last entry counted here as well
        unexp_r <= 1'b0;
        count_r <= live_r + CW'(last_live);
        rup_r <= trup_r && !(last_live && !rd_up);
        fault_r <= tfault_r || (live_r == '0 && !last_live) ||
                   (last_live && (rd_mpid == local_mpid_r || rd_defect));
      end
    end
  end

  // result register
  logic [2:0] st_r;
  logic [2:0] st_nxt;
  always_comb begin
    if (is_tick_r) begin
      st_nxt = 3'(ccm_pkg::ST_CHECK_DONE);
    end else if (pre_done_r) begin
      st_nxt = pre_status_r;
    end else if (found_r) begin
      st_nxt = 3'(ccm_pkg::ST_UPDATED);
    end else if (free_ok_r) begin
      st_nxt = 3'(ccm_pkg::ST_INSERTED);
    end else begin
      st_nxt = 3'(ccm_pkg::ST_TABLE_FULL);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      st_r <= st_nxt;
    end
  end

  assign out_status = st_r;
  assign out_fault = fault_r;
  assign out_remote_up = rup_r;
  assign out_remote_count = 9'(count_r);
  assign out_unexpected_seen = unexp_r;

endmodule
`default_nettype wire

[sv/ccm_remote_endpoint_monitor.sv]
// CCM remote endpoint monitor, receive side of a continuity check.
// Input channel (in_valid/in_ready): one item is either a received CCM
// (in_operation 0) or a fault-check tick (in_operation 1).
// Result channel (out_valid/out_ready): one result per item, carrying the
// status code and the fault, remote-up, entry count and unexpected flags
// as they stand after that item.
// A wrong opcode or MAID mismatch is answered from the dispatch state,
// with no table scan; a CCM scans the table until its MPID is found or
// the last entry has been evaluated, so a new MPID or a full table scans
// every entry; a tick scans every entry. Each table entry is first read
// from the entry memory, then compared and updated.
// One item is in work at a time; in_ready is high only when idle, so the
// next item is taken in the cycle after a result is loaded, even while an
// earlier result still waits on the output.
// A stalled receiver holds the result; the block holds at its final step
// until the result register is free.
// Reset (synchronous, rst_n low) empties the table, clears all flags
// except remote-up, which resets to 1, and clears the configuration.
// Configuration writes (cfg_we) are taken any cycle but are meant for idle.
`default_nettype none
module ccm_remote_endpoint_monitor #(
  parameter int unsigned MAX_REMOTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_opcode,
  input  wire logic [7:0]  in_flags,
  input  wire logic [15:0] in_short_mpid,
  input  wire logic [63:0] in_long_mpid,
  input  wire logic [7:0]  in_opdown_byte,
  input  wire logic [63:0] in_maid_word_0,
  input  wire logic [63:0] in_maid_word_1,
  input  wire logic [63:0] in_maid_word_2,
  input  wire logic [63:0] in_maid_word_3,
  input  wire logic [63:0] in_maid_word_4,
  input  wire logic [63:0] in_maid_word_5,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_fault,
  output logic             out_remote_up,
  output logic [8:0]       out_remote_count,
  output logic             out_unexpected_seen
);

  ccm_pkg::ctl_t ctl;
  ccm_pkg::sts_t sts;

  ccm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ccm_datapath #(.MAX_REMOTES(MAX_REMOTES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_opcode          (in_opcode),
    .in_flags           (in_flags),
    .in_short_mpid      (in_short_mpid),
    .in_long_mpid       (in_long_mpid),
    .in_opdown_byte     (in_opdown_byte),
    .in_maid_word_0     (in_maid_word_0),
    .in_maid_word_1     (in_maid_word_1),
    .in_maid_word_2     (in_maid_word_2),
    .in_maid_word_3     (in_maid_word_3),
    .in_maid_word_4     (in_maid_word_4),
    .in_maid_word_5     (in_maid_word_5),
    .out_status         (out_status),
    .out_fault          (out_fault),
    .out_remote_up      (out_remote_up),
    .out_remote_count   (out_remote_count),
    .out_unexpected_seen(out_unexpected_seen)
  );

endmodule
`default_nettype wire

[sv/ccm_checker.sv]
`default_nettype none
`include "ccm_remote_endpoint_monitor_macros.svh"
module ccm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_fault,
  input wire logic [8:0] out_remote_count
);

  logic range_ok;
  logic empty_check;
  assign range_ok = out_status <= 3'(ccm_pkg::ST_CHECK_DONE);
  assign empty_check = out_valid && out_status == 3'(ccm_pkg::ST_CHECK_DONE) &&
                       out_remote_count == 9'd0;

  // stalled result holds its status
  `CCM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(out_status), "result changed while stalled")

  // status code stays within defined codes
  `CCM_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, range_ok, "status code out of range")

  // a check with an empty table reports a fault
  `CCM_ASSERT_IMP(a_empty_fault, clk, rst_n, empty_check, out_fault, "empty table without fault")

  // accepted item blocks further input directly after it is taken
  `CCM_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second item taken during work")

endmodule

bind ccm_remote_endpoint_monitor ccm_checker u_ccm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_fault       (out_fault),
  .out_remote_count(out_remote_count)
);
`default_nettype wire
